// ===== rtl/tvbd_pkg.sv =====
package tvbd_pkg;

   localparam int PIXEL_W    = 8;
   localparam int FU_W       = 4;
   localparam int VT_W       = 14;
   localparam int RATIO_W    = 16;
   localparam int FP_W       = 13;
   localparam int CNT_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MEAN_STEPS = PIXEL_W;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = 13'd8191;

   localparam logic [CSR_IDX_W-1:0] REG_FRAMES_USED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VAR_THRESH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_Q16   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_PIX   = 2'd3;

   localparam logic [FU_W-1:0]    FRAMES_USED_RST = 4'd8;
   localparam logic [VT_W-1:0]    VAR_THRESH_RST  = 14'd0;
   localparam logic [RATIO_W-1:0] RATIO_Q16_RST   = 16'd13107;
   localparam logic [FP_W-1:0]    FRAME_PIX_RST   = 13'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_VAR,
      ST_CMP,
      ST_FIN,
      ST_MUL,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/tvbd_if.sv =====
interface tvbd_req_if import tvbd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_end;

   modport source (output valid, output req_type, output pixel, output frame_end,
                   input ready);
   modport sink   (input valid, input req_type, input pixel, input frame_end,
                   output ready);
endinterface

interface tvbd_rsp_if import tvbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             blink;
   logic [CNT_W-1:0] changed_count;
   logic             evaluated;

   modport source (output valid, output blink, output changed_count, output evaluated,
                   input ready);
   modport sink   (input valid, input blink, input changed_count, input evaluated,
                   output ready);
endinterface

interface tvbd_csr_if import tvbd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/temporal_variance_blink_detector_core.sv =====
// a pixel outside a full history goes to ST_FIN; a judged pixel first runs ST_SUM,
// ST_DIV, ST_VAR and ST_CMP, paced by the single read port of the frame store (two
// passes over n frames, n = effective frames_used) and the 8-step bit-serial mean
// divider; a frame's last pixel passes ST_MUL (ratio product) before the word is shown
// one item at a time: ready is high only while idle; results wait in an output register
// reset is synchronous, active high: control state and registers return to defaults
module temporal_variance_blink_detector_core import tvbd_pkg::*; #(
   parameter int FRAMES_MAX = 8,
   parameter int PIXELS_MAX = 4096
) (
   input  logic       clock,
   input  logic       reset,
   tvbd_req_if.sink   req_chan,
   tvbd_rsp_if.source rsp_chan,
   tvbd_csr_if.sink   csr_chan
);

   localparam int NW  = $clog2(FRAMES_MAX + 1);
   localparam int SLW = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
   localparam int PW  = $clog2(PIXELS_MAX);
   localparam int FPW = $clog2(PIXELS_MAX + 1);
   localparam int AW  = 2 * PIXEL_W + NW;
   localparam int TW  = VT_W + 1 + NW;
   localparam int PRW = RATIO_W + FPW;
   localparam int LW  = CNT_W + RATIO_W;
   localparam int BW  = (LW > PRW) ? LW : PRW;
   localparam int DIW = $clog2(MEAN_STEPS);

   state_type state_ff, state_in;

   logic [FU_W-1:0]    fu_ff, fu_in;
   logic [VT_W-1:0]    vt_ff, vt_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [FP_W-1:0]    fp_ff, fp_in;

   logic [NW-1:0]    hc_ff, hc_in;
   logic [SLW-1:0]   ws_ff, ws_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0] oc_ff, oc_in;

   logic [NW-1:0]      k_ff, k_in;
   logic [SLW-1:0]     rd_slot_ff, rd_slot_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [PIXEL_W-1:0] rdata_ff;
   logic [PIXEL_W-1:0] d_ff, d_in;
   logic               dv_ff, dv_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [PIXEL_W-1:0] mean_ff, mean_in;
   logic [DIW-1:0]     div_i_ff, div_i_in;
   logic [TW-1:0]      thrn_ff, thrn_in;
   logic [PRW-1:0]     prod_ff, prod_in;
   logic               fe_ff, fe_in;
   logic               judged_ff, judged_in;

   logic               rsp_vld_ff, rsp_vld_in;
   logic               blink_ff, blink_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               eval_ff, eval_in;

   logic [PIXEL_W-1:0] store_mem [0:FRAMES_MAX-1][0:PIXELS_MAX-1];
   logic               mem_we;

   logic [NW-1:0]      n_eff;
   logic [FPW-1:0]     fp_eff;
   logic               req_acc;
   logic               issue;
   logic               judged_c;
   logic               last_c;
   logic               blink_c;
   logic [AW-1:0]      trial;
   logic [SLW-1:0]     slot_prev;
   logic [SLW-1:0]     ws_next;

   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_chan.ready = !reset;
   assign req_acc        = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.blink         = blink_ff;
   assign rsp_chan.changed_count = cnt_ff;
   assign rsp_chan.evaluated     = eval_ff;

   // out-of-range settings fold to the nearest legal value
   assign n_eff  = (fu_ff == '0) ? NW'(1) :
                   ((32'(fu_ff) > FRAMES_MAX) ? NW'(FRAMES_MAX) : NW'(fu_ff));
   assign fp_eff = (fp_ff == '0) ? FPW'(1) :
                   ((32'(fp_ff) > PIXELS_MAX) ? FPW'(PIXELS_MAX) : FPW'(fp_ff));

   assign judged_c  = (32'(hc_ff) + 32'd1) >= 32'(n_eff);
   assign last_c    = fe_ff || ((32'(pos_ff) + 32'd1) >= 32'(fp_eff));
   assign blink_c   = judged_ff && (BW'({oc_ff, {RATIO_W{1'b0}}}) > BW'(prod_ff));
   assign issue     = (k_ff != n_eff);
   assign trial     = AW'(n_eff) << div_i_ff;
   assign slot_prev = (rd_slot_ff == '0) ? SLW'(FRAMES_MAX - 1) : rd_slot_ff - SLW'(1);
   assign ws_next   = (ws_ff == SLW'(FRAMES_MAX - 1)) ? '0 : ws_ff + SLW'(1);

   always_comb begin
      state_in   = state_ff;
      fu_in      = fu_ff;
      vt_in      = vt_ff;
      ratio_in   = ratio_ff;
      fp_in      = fp_ff;
      hc_in      = hc_ff;
      ws_in      = ws_ff;
      pos_in     = pos_ff;
      oc_in      = oc_ff;
      k_in       = k_ff;
      rd_slot_in = rd_slot_ff;
      rd_vld_in  = 1'b0;
      d_in       = d_ff;
      dv_in      = 1'b0;
      acc_in     = acc_ff;
      mean_in    = mean_ff;
      div_i_in   = div_i_ff;
      thrn_in    = thrn_ff;
      prod_in    = prod_ff;
      fe_in      = fe_ff;
      judged_in  = judged_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      blink_in   = blink_ff;
      cnt_in     = cnt_ff;
      eval_in    = eval_ff;
      mem_we     = 1'b0;

      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            REG_FRAMES_USED: fu_in    = csr_chan.data[FU_W-1:0];
            REG_VAR_THRESH:  vt_in    = csr_chan.data[VT_W-1:0];
            REG_RATIO_Q16:   ratio_in = csr_chan.data[RATIO_W-1:0];
            REG_FRAME_PIX:   fp_in    = csr_chan.data[FP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.req_type) begin
                  hc_in  = '0;
                  ws_in  = '0;
                  pos_in = '0;
                  oc_in  = '0;
               end else begin
                  mem_we     = 1'b1;
                  fe_in      = req_chan.frame_end;
                  judged_in  = judged_c;
                  rd_slot_in = ws_ff;
                  k_in       = '0;
                  acc_in     = '0;
                  state_in   = judged_c ? ST_SUM : ST_FIN;
               end
            end
         end
         ST_SUM: begin
            // newest frame first, walking back through the ring
            rd_vld_in = issue;
            if (issue) begin
               k_in       = k_ff + NW'(1);
               rd_slot_in = slot_prev;
            end
            if (rd_vld_ff) begin
               acc_in = acc_ff + AW'(rdata_ff);
            end
            if (!issue && !rd_vld_ff) begin
               div_i_in = DIW'(MEAN_STEPS - 1);
               mean_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            thrn_in = (TW'(vt_ff) + TW'(1)) * TW'(n_eff);
            if (acc_ff >= trial) begin
               acc_in  = acc_ff - trial;
               mean_in = {mean_ff[PIXEL_W-2:0], 1'b1};
            end else begin
               mean_in = {mean_ff[PIXEL_W-2:0], 1'b0};
            end
            div_i_in = div_i_ff - DIW'(1);
            if (div_i_ff == '0) begin
               k_in       = '0;
               rd_slot_in = ws_ff;
               acc_in     = '0;
               state_in   = ST_VAR;
            end
         end
         ST_VAR: begin
            rd_vld_in = issue;
            if (issue) begin
               k_in       = k_ff + NW'(1);
               rd_slot_in = slot_prev;
            end
            dv_in = rd_vld_ff;
            d_in  = (rdata_ff >= mean_ff) ? (rdata_ff - mean_ff) : (mean_ff - rdata_ff);
            if (dv_ff) begin
               acc_in = acc_ff + AW'(16'(d_ff) * 16'(d_ff));
            end
            if (!issue && !rd_vld_ff && !dv_ff) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // floor(sum/n) > t  <=>  sum >= (t+1)*n
            if ((acc_ff >= AW'(thrn_ff)) && (oc_ff != COUNT_LIMIT)) begin
               oc_in = oc_ff + CNT_W'(1);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (last_c) begin
               state_in = ST_MUL;
            end else begin
               pos_in   = pos_ff + PW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            prod_in  = PRW'(ratio_ff) * PRW'(fp_eff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               blink_in   = blink_c;
               cnt_in     = judged_ff ? oc_ff : '0;
               eval_in    = judged_ff;
               pos_in     = '0;
               oc_in      = '0;
               if (blink_c) begin
                  hc_in = '0;
                  ws_in = '0;
               end else begin
                  ws_in = ws_next;
                  if (32'(hc_ff) < FRAMES_MAX) begin
                     hc_in = hc_ff + NW'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fu_ff      <= FRAMES_USED_RST;
         vt_ff      <= VAR_THRESH_RST;
         ratio_ff   <= RATIO_Q16_RST;
         fp_ff      <= FRAME_PIX_RST;
         hc_ff      <= '0;
         ws_ff      <= '0;
         pos_ff     <= '0;
         oc_ff      <= '0;
         k_ff       <= '0;
         rd_vld_ff  <= 1'b0;
         dv_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         fu_ff      <= fu_in;
         vt_ff      <= vt_in;
         ratio_ff   <= ratio_in;
         fp_ff      <= fp_in;
         hc_ff      <= hc_in;
         ws_ff      <= ws_in;
         pos_ff     <= pos_in;
         oc_ff      <= oc_in;
         k_ff       <= k_in;
         rd_vld_ff  <= rd_vld_in;
         dv_ff      <= dv_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= rd_slot_in;
      d_ff       <= d_in;
      acc_ff     <= acc_in;
      mean_ff    <= mean_in;
      div_i_ff   <= div_i_in;
      thrn_ff    <= thrn_in;
      prod_ff    <= prod_in;
      fe_ff      <= fe_in;
      judged_ff  <= judged_in;
      blink_ff   <= blink_in;
      cnt_ff     <= cnt_in;
      eval_ff    <= eval_in;
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[ws_ff][pos_ff] <= req_chan.pixel;
      end
      rdata_ff <= store_mem[rd_slot_ff][pos_ff];
   end

endmodule

// ===== rtl/tvbd_checker.sv =====
module tvbd_checker import tvbd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_type,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_blink,
   input logic [CNT_W-1:0] rsp_changed_count,
   input logic             rsp_evaluated
);

   // a result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_blink) && $stable(rsp_changed_count) && $stable(rsp_evaluated))
      else $error("result word changed while stalled");

   // an unjudged frame reports nothing
   a_unjudged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evaluated |-> !rsp_blink && (rsp_changed_count == '0))
      else $error("unjudged frame carries blink or count");

   // after a pixel word is taken, ready is low in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type |=> !req_ready)
      else $error("ready right after a pixel word");

endmodule

bind temporal_variance_blink_detector_core tvbd_checker u_tvbd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_type          (req_chan.req_type),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_blink         (rsp_chan.blink),
   .rsp_changed_count (rsp_chan.changed_count),
   .rsp_evaluated     (rsp_chan.evaluated)
);
